/* design/imhdk_pkg.sv */
// shared types, defaults and codes of the indexed min-heap
package imhdk_pkg;

   localparam int NODES_DEF     = 256;
   localparam int DIST_BITS_DEF = 24;

   typedef enum logic {
      OP_RELAX = 1'b0,
      OP_POP   = 1'b1
   } op_type;

   typedef struct packed {
      op_type      operation;
      logic [7:0]  node_id;
      logic [7:0]  via_node;
      logic [23:0] candidate_distance;
   } req_word_type;

   typedef struct packed {
      logic        accepted;
      logic        empty_res;
      logic [7:0]  popped_node;
      logic [23:0] popped_distance;
      logic [7:0]  popped_via;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_R_CHK,
      ST_SU_LOOP,
      ST_SU_CMP,
      ST_SU_END,
      ST_P1,
      ST_P2,
      ST_P3,
      ST_P4,
      ST_SD_START,
      ST_SD_A,
      ST_SD_B,
      ST_SD_C,
      ST_SD_END,
      ST_FIN
   } state_type;

endpackage

/* design/imhdk_if.sv */
// valid/ready channel interfaces for request and response words
interface imhdk_req_if;
   import imhdk_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface imhdk_rsp_if;
   import imhdk_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

/* design/imhdk_ram.sv */
// generic dual-port ram, one write and one registered read per cycle
module imhdk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* design/indexed_min_heap_decrease_key.sv */
// indexed binary min-heap with decrease-key, top level
//
// req carries relax and pop words, rsp returns exactly one word per request,
// in order. both are valid/ready channels; a word moves when both are high.
// a relax offers a distance for a node; if taken it is stored with its
// predecessor and the node is inserted or sifted up. a pop removes the node
// with the least distance and reports it, or flags an empty heap.
// one request is worked at a time. node state and heap slots sit in two
// single-read rams, so each heap level costs one ram round trip per read.
// a relax reads the node entry and is refused or taken; a taken relax is
// then compared with one parent per level on its way up. a pop reads the
// root and last slots and their entries, then descends one level at a time
// until a child compare stops it; a pop on an empty heap reads no ram.
// after reset the node ram is swept clear, one entry a cycle; req.ready
// stays low meanwhile. the response sits in an output register; a new
// request is taken while it waits, and the block holds its next response
// until the receiver takes the pending one.
module indexed_min_heap_decrease_key #(
   parameter int NODES     = imhdk_pkg::NODES_DEF,
   parameter int DIST_BITS = imhdk_pkg::DIST_BITS_DEF
) (
   input logic          clock,
   input logic          reset,
   imhdk_req_if.sink    req,
   imhdk_rsp_if.source  rsp
);
   import imhdk_pkg::*;

   localparam int NW        = $clog2(NODES);
   localparam int HW        = $clog2(NODES + 1);
   localparam int DW        = DIST_BITS;
   localparam int PRED_LO   = 0;
   localparam int DIST_LO   = 8;
   localparam int POS_LO    = 8 + DW;
   localparam int REACH_BIT = 8 + DW + HW;
   localparam int EW        = 9 + DW + HW;

   state_type state_ff, state_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic [HW-1:0] count_ff, count_in;
   logic [HW-1:0] idx_ff, idx_in;
   logic [NW-1:0] nd_ff, nd_in;
   logic [7:0]    via_ff, via_in;
   logic [DW-1:0] d_ff, d_in;
   logic [NW-1:0] pn_ff, pn_in;
   logic [NW-1:0] root_ff, root_in;
   logic [NW-1:0] last_ff, last_in;
   logic [NW-1:0] lnode_ff, lnode_in;
   logic [NW-1:0] rnode_ff, rnode_in;
   logic [EW-1:0] rootent_ff, rootent_in;
   logic [EW-1:0] lastent_ff, lastent_in;
   logic [EW-1:0] lent_ff, lent_in;
   logic          has_r_ff, has_r_in;
   rsp_word_type  res_ff, res_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          nwr_en, hwr_en;
   logic [NW-1:0] nwr_addr, nrd_addr, hwr_addr, hrd_addr;
   logic [EW-1:0] nwr_data, nrd_data;
   logic [NW-1:0] hwr_data, hrd_data;

   logic [31:0]   id32, cand32, dist32, node32;
   logic [HW:0]   two, two1, n_ext, jslot;
   logic [EW-1:0] jent;
   logic [NW-1:0] jnode;
   logic          choose_r;
   logic [HW-1:0] pos_new, half;

   function automatic logic [NW-1:0] slot_addr(input logic [HW:0] slot);
      logic [HW:0] a;
      a = slot - (HW+1)'(1);
      return a[NW-1:0];
   endfunction

   function automatic logic [EW-1:0] with_pos(input logic [EW-1:0] e,
                                              input logic [HW-1:0] p);
      logic [EW-1:0] r;
      r = e;
      r[POS_LO +: HW] = p;
      return r;
   endfunction

   imhdk_ram #(.WIDTH(EW), .DEPTH(NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (nwr_en),
      .wr_addr (nwr_addr),
      .wr_data (nwr_data),
      .rd_addr (nrd_addr),
      .rd_data (nrd_data)
   );

   imhdk_ram #(.WIDTH(NW), .DEPTH(NODES)) u_heap_ram (
      .clock   (clock),
      .wr_en   (hwr_en),
      .wr_addr (hwr_addr),
      .wr_data (hwr_data),
      .rd_addr (hrd_addr),
      .rd_data (hrd_data)
   );

   assign id32   = 32'(req.word.node_id);
   assign cand32 = 32'(req.word.candidate_distance);
   assign dist32 = 32'(rootent_in[DIST_LO +: DW]);
   assign node32 = 32'(root_ff);
   assign two    = {idx_ff, 1'b0};
   assign two1   = two + (HW+1)'(1);
   assign n_ext  = (HW+1)'(count_ff);
   assign half   = idx_ff >> 1;

   always_comb begin
      choose_r = has_r_ff &&
                 (lent_ff[DIST_LO +: DW] > nrd_data[DIST_LO +: DW]);
      jent  = choose_r ? nrd_data : lent_ff;
      jnode = choose_r ? rnode_ff : lnode_ff;
      jslot = choose_r ? two1 : two;
      pos_new = nrd_data[POS_LO +: HW];
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      nd_in      = nd_ff;
      via_in     = via_ff;
      d_in       = d_ff;
      pn_in      = pn_ff;
      root_in    = root_ff;
      last_in    = last_ff;
      lnode_in   = lnode_ff;
      rnode_in   = rnode_ff;
      rootent_in = rootent_ff;
      lastent_in = lastent_ff;
      lent_in    = lent_ff;
      has_r_in   = has_r_ff;
      res_in     = res_ff;
      nwr_en     = 1'b0;
      nwr_addr   = nd_ff;
      nwr_data   = '0;
      nrd_addr   = nd_ff;
      hwr_en     = 1'b0;
      hwr_addr   = '0;
      hwr_data   = nd_ff;
      hrd_addr   = '0;
      req.ready  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_word_in  = rsp_word_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            nwr_en   = 1'b1;
            nwr_addr = clr_ff;
            clr_in   = clr_ff + NW'(1);
            if (clr_ff == NW'(NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req.ready = 1'b1;
            nd_in     = id32[NW-1:0];
            via_in    = req.word.via_node;
            d_in      = cand32[DW-1:0];
            nrd_addr  = id32[NW-1:0];
            hrd_addr  = '0;
            res_in    = '0;
            if (req.valid) begin
               if (req.word.operation == OP_RELAX) begin
                  state_in = (id32 < 32'(NODES)) ? ST_R_CHK : ST_FIN;
               end else if (count_ff == '0) begin
                  res_in.empty_res = 1'b1;
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_P1;
               end
            end
         end
         ST_R_CHK: begin
            if (nrd_data[REACH_BIT] && (d_ff >= nrd_data[DIST_LO +: DW])) begin
               state_in = ST_FIN;
            end else begin
               res_in.accepted = 1'b1;
               if (pos_new == '0) begin
                  count_in = count_ff + HW'(1);
                  idx_in   = count_ff + HW'(1);
               end else begin
                  idx_in   = pos_new;
               end
               hrd_addr = slot_addr((HW+1)'(idx_in >> 1));
               state_in = (idx_in == HW'(1)) ? ST_SU_END : ST_SU_LOOP;
            end
         end
         ST_SU_LOOP: begin
            pn_in    = hrd_data;
            nrd_addr = hrd_data;
            state_in = ST_SU_CMP;
         end
         ST_SU_CMP: begin
            if (d_ff < nrd_data[DIST_LO +: DW]) begin
               hwr_en   = 1'b1;
               hwr_addr = slot_addr((HW+1)'(idx_ff));
               hwr_data = pn_ff;
               nwr_en   = 1'b1;
               nwr_addr = pn_ff;
               nwr_data = with_pos(nrd_data, idx_ff);
               idx_in   = half;
               hrd_addr = slot_addr((HW+1)'(half >> 1));
               state_in = (half == HW'(1)) ? ST_SU_END : ST_SU_LOOP;
            end else begin
               state_in = ST_SU_END;
            end
         end
         ST_SU_END: begin
            hwr_en   = 1'b1;
            hwr_addr = slot_addr((HW+1)'(idx_ff));
            hwr_data = nd_ff;
            nwr_en   = 1'b1;
            nwr_addr = nd_ff;
            nwr_data = {1'b1, idx_ff, d_ff, via_ff};
            state_in = ST_FIN;
         end
         ST_P1: begin
            root_in  = hrd_data;
            hrd_addr = slot_addr((HW+1)'(count_ff));
            count_in = count_ff - HW'(1);
            state_in = ST_P2;
         end
         ST_P2: begin
            last_in  = hrd_data;
            nrd_addr = root_ff;
            state_in = ST_P3;
         end
         ST_P3: begin
            rootent_in = nrd_data;
            res_in.popped_node     = node32[7:0];
            res_in.popped_distance = dist32[23:0];
            res_in.popped_via      = nrd_data[PRED_LO +: 8];
            nrd_addr = last_ff;
            state_in = ST_P4;
         end
         ST_P4: begin
            lastent_in = nrd_data;
            idx_in     = HW'(1);
            state_in   = ST_SD_START;
         end
         ST_SD_START: begin
            hrd_addr = slot_addr(two);
            state_in = (two <= n_ext) ? ST_SD_A : ST_SD_END;
         end
         ST_SD_A: begin
            lnode_in = hrd_data;
            nrd_addr = hrd_data;
            hrd_addr = slot_addr(two1);
            has_r_in = (two1 <= n_ext);
            state_in = ST_SD_B;
         end
         ST_SD_B: begin
            lent_in  = nrd_data;
            rnode_in = hrd_data;
            nrd_addr = hrd_data;
            state_in = ST_SD_C;
         end
         ST_SD_C: begin
            if (jent[DIST_LO +: DW] >= lastent_ff[DIST_LO +: DW]) begin
               state_in = ST_SD_END;
            end else begin
               hwr_en   = 1'b1;
               hwr_addr = slot_addr((HW+1)'(idx_ff));
               hwr_data = jnode;
               nwr_en   = 1'b1;
               nwr_addr = jnode;
               nwr_data = with_pos(jent, idx_ff);
               idx_in   = jslot[HW-1:0];
               state_in = ST_SD_START;
            end
         end
         ST_SD_END: begin
            hwr_en   = 1'b1;
            hwr_addr = slot_addr((HW+1)'(idx_ff));
            hwr_data = last_ff;
            nwr_en   = 1'b1;
            nwr_addr = last_ff;
            nwr_data = with_pos(lastent_ff, idx_ff);
            // popped node leaves the heap after the last entry is placed
            has_r_in = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (has_r_ff) begin
               nwr_en   = 1'b1;
               nwr_addr = root_ff;
               nwr_data = with_pos(rootent_ff, '0);
               has_r_in = 1'b0;
            end
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         has_r_ff     <= 1'b0;
         idx_ff       <= HW'(1);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         has_r_ff     <= has_r_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      nd_ff       <= nd_in;
      via_ff      <= via_in;
      d_ff        <= d_in;
      pn_ff       <= pn_in;
      root_ff     <= root_in;
      last_ff     <= last_in;
      lnode_ff    <= lnode_in;
      rnode_ff    <= rnode_in;
      rootent_ff  <= rootent_in;
      lastent_ff  <= lastent_in;
      lent_ff     <= lent_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.word  = rsp_word_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= HW'(NODES))
      else $error("heap count above node count");

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req.ready)
      else $error("request taken during clearing sweep");

   a_siftup_above_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SU_CMP) |-> (idx_ff > HW'(1)))
      else $error("sift up compare at root slot");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P1) |=> (count_ff == $past(count_ff) - HW'(1)))
      else $error("pop did not shrink heap");
endmodule
